### rtl/atpw_pkg.sv
`timescale 1ns / 1ps

package atpw_pkg;

    // Screen geometry
    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 128;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int CELL_W    = 11;
    localparam int COLOR_W   = 3;
    localparam int ROWS_W    = 6;
    localparam int COLS_W    = 8;
    localparam int CFG_W     = 8;

    // Configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd24;
    localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;

    // Byte codes
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] FINAL_LOW  = 8'h40;
    localparam logic [7:0] FINAL_HIGH = 8'h7E;
    localparam logic [7:0] CSI_OPEN   = 8'h5B;
    localparam logic [7:0] SEMICOLON  = 8'h3B;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;
    localparam logic [7:0] SGR_FINAL  = 8'h6D;

    localparam logic [6:0] COLOR_FIRST = 7'd30;
    localparam logic [6:0] COLOR_LAST  = 7'd37;
    localparam logic [6:0] NUM_SAT     = 7'd127;

    localparam logic [COLOR_W-1:0] PEN_RESET  = 3'd7;
    localparam logic [CELL_W-1:0]  BLANK_CELL = 11'h720;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ESC   = 4'b0010,
        PH_CSI   = 4'b0100,
        PH_OTHER = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        SH_START  = 3'd0,
        SH_FIRST  = 3'd1,
        SH_SEMI   = 3'd2,
        SH_LATER  = 3'd3,
        SH_BROKEN = 3'd4
    } shape_t;

endpackage

### rtl/atpw_byte_if.sv
`timescale 1ns / 1ps

interface atpw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

### rtl/atpw_cell_if.sv
`timescale 1ns / 1ps

interface atpw_cell_if;
    logic       valid;
    logic       ready;
    logic       cell_written;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
    logic [7:0] cell_char;
    logic [2:0] cell_color;
    logic [4:0] cursor_row_now;
    logic [6:0] cursor_col_now;

    modport source (
        output valid, output cell_written, output cell_row, output cell_col,
        output cell_char, output cell_color, output cursor_row_now,
        output cursor_col_now, input ready
    );
    modport sink (
        input valid, input cell_written, input cell_row, input cell_col,
        input cell_char, input cell_color, input cursor_row_now,
        input cursor_col_now, output ready
    );
endinterface

### rtl/ansi_text_plane_writer.sv
`timescale 1ns / 1ps

// Terminal text plane writer.
// byte_chan (valid/ready) carries one byte of terminal output per transfer.
// cell_chan (valid/ready) returns exactly one result per byte: the cell it
// wrote (if any) and the cursor position after the byte.
// Configuration: cfg_we / cfg_index / cfg_wdata write rows_in_use (index 0)
// or cols_in_use (index 1); write only while the block is idle.
// Output: a result is registered and appears on cell_chan in the cycle after its byte transfer.
// Throughput: one byte per cycle while no result is stalled; the decode and
// cursor update are combinational and the screen store takes one write per cycle.
// Reset: cursor at 0,0, pen white, no sequence open. The screen store is then
// cleared to white spaces by a pass over all 4096 cells, one cell per cycle;
// byte_chan.ready stays low during that pass.
// Stall: the output register holds its result until cell_chan.ready; while a
// result waits and the receiver is stalled, byte_chan.ready drops. When the
// receiver takes the result, a new byte is accepted in the same cycle.
module ansi_text_plane_writer
    import atpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    atpw_byte_if.sink            byte_chan,
    atpw_cell_if.source          cell_chan,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // Move the cursor down one row, clamped at the last row in use.
    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROWS_W-1:0] rows);
        logic [ROWS_W-1:0] r;
        logic [ROWS_W-1:0] last;
        r    = {1'b0, row} + ROWS_W'(1);
        last = rows - ROWS_W'(1);
        return (r > last) ? last[ROW_W-1:0] : r[ROW_W-1:0];
    endfunction

    // Configuration registers
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;

    // Parser and cursor state
    logic [ROW_W-1:0]   crow_reg, crow_next;
    logic [COL_W-1:0]   ccol_reg, ccol_next;
    logic [COLOR_W-1:0] pen_reg, pen_next;
    phase_t             phase_reg, phase_next;
    logic [6:0]         num_reg, num_next;
    shape_t             shape_reg, shape_next;

    // Screen clearing pass
    logic               clear_reg;
    logic [ADDR_W-1:0]  clear_addr_reg;

    // Output register
    logic               out_valid_reg;
    logic               wr_reg, wr_next;
    logic [ROW_W-1:0]   wrow_reg;
    logic [COL_W-1:0]   wcol_reg;
    logic [7:0]         wchar_reg;
    logic [COLOR_W-1:0] wcolor_reg;
    logic [ROW_W-1:0]   orow_reg;
    logic [COL_W-1:0]   ocol_reg;

    // Screen store: color in bits 10..8, character in 7..0
    logic [CELL_W-1:0]  screen_mem [CELLS];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CELL_W-1:0]  mem_data;

    logic               in_xfer;
    logic               out_xfer;
    logic [ROWS_W-1:0]  rows_lim;
    logic [COLS_W-1:0]  cols_lim;
    logic [7:0]         b;
    logic               is_final;
    logic [COL_W-1:0]   col_inc;
    logic [10:0]        num_acc;

    assign b         = byte_chan.byte_in;
    assign out_xfer  = out_valid_reg && cell_chan.ready;
    assign byte_chan.ready = !clear_reg && (!out_valid_reg || cell_chan.ready);
    assign in_xfer   = byte_chan.valid && byte_chan.ready;

    // Clamp the area in use to the screen store; a zero count becomes one
    always_comb
    begin
        if (rows_reg == '0)
            rows_lim = ROWS_W'(1);
        else if (rows_reg > ROWS_W'(MAX_ROWS))
            rows_lim = ROWS_W'(MAX_ROWS);
        else
            rows_lim = rows_reg;

        if (cols_reg == '0)
            cols_lim = COLS_W'(1);
        else if (cols_reg > COLS_W'(MAX_COLS))
            cols_lim = COLS_W'(MAX_COLS);
        else
            cols_lim = cols_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS: rows_reg <= cfg_wdata[ROWS_W-1:0];
                REG_COLS: cols_reg <= cfg_wdata[COLS_W-1:0];
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    // Byte decode: escape sequences, newline, and a cell write for any other byte
    always_comb
    begin
        crow_next  = crow_reg;
        ccol_next  = ccol_reg;
        pen_next   = pen_reg;
        phase_next = phase_reg;
        num_next   = num_reg;
        shape_next = shape_reg;
        wr_next    = 1'b0;
        is_final   = b inside {[FINAL_LOW:FINAL_HIGH]};
        col_inc    = ccol_reg + COL_W'(1);
        num_acc    = {1'b0, num_reg, 3'b000} + {3'b000, num_reg, 1'b0}
                   + {3'b000, b - DIGIT_0};

        case (phase_reg)
            PH_ESC:
            begin
                if (b == CSI_OPEN)
                begin
                    phase_next = PH_CSI;
                    num_next   = '0;
                    shape_next = SH_START;
                end
                else
                    phase_next = is_final ? PH_IDLE : PH_OTHER;
            end
            PH_CSI:
            begin
                if (is_final)
                begin
                    // Only a well-formed SGR with first value 30..37 sets the pen
                    if (b == SGR_FINAL && (shape_reg == SH_FIRST || shape_reg == SH_LATER)
                        && num_reg >= COLOR_FIRST && num_reg <= COLOR_LAST)
                        pen_next = COLOR_W'(num_reg - COLOR_FIRST);
                    phase_next = PH_IDLE;
                end
                else if (b inside {[DIGIT_0:DIGIT_9]})
                begin
                    if (shape_reg == SH_START || shape_reg == SH_FIRST)
                    begin
                        num_next   = (num_acc > 11'(NUM_SAT)) ? NUM_SAT : num_acc[6:0];
                        shape_next = SH_FIRST;
                    end
                    else if (shape_reg == SH_SEMI)
                        shape_next = SH_LATER;
                end
                else if (b == SEMICOLON)
                    shape_next = (shape_reg == SH_FIRST || shape_reg == SH_LATER)
                               ? SH_SEMI : SH_BROKEN;
                else
                    shape_next = SH_BROKEN;
            end
            PH_OTHER:
            begin
                if (is_final)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                if (b == ESC_BYTE)
                    phase_next = PH_ESC;
                else if (b == NEWLINE)
                begin
                    ccol_next = '0;
                    crow_next = next_row(crow_reg, rows_lim);
                end
                else
                begin
                    // Write only inside the area in use, then advance and wrap
                    wr_next = ({1'b0, crow_reg} < rows_lim) && ({1'b0, ccol_reg} < cols_lim);
                    if ({1'b0, col_inc} >= cols_lim || col_inc == '0)
                    begin
                        ccol_next = '0;
                        crow_next = next_row(crow_reg, rows_lim);
                    end
                    else
                        ccol_next = col_inc;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crow_reg  <= '0;
            ccol_reg  <= '0;
            pen_reg   <= PEN_RESET;
            phase_reg <= PH_IDLE;
            num_reg   <= '0;
            shape_reg <= SH_START;
        end
        else if (in_xfer)
        begin
            crow_reg  <= crow_next;
            ccol_reg  <= ccol_next;
            pen_reg   <= pen_next;
            phase_reg <= phase_next;
            num_reg   <= num_next;
            shape_reg <= shape_next;
        end
    end

    // Clearing pass: sweep every cell once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(CELLS - 1))
                clear_reg <= 1'b0;
        end
    end

    assign mem_we   = clear_reg || (in_xfer && wr_next);
    assign mem_addr = clear_reg ? clear_addr_reg : {crow_reg, ccol_reg};
    assign mem_data = clear_reg ? BLANK_CELL : {pen_reg, b};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_addr] <= mem_data;
    end

    // Output register: load on byte transfer, drop after the result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_xfer)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            wr_reg     <= wr_next;
            wrow_reg   <= wr_next ? crow_reg : '0;
            wcol_reg   <= wr_next ? ccol_reg : '0;
            wchar_reg  <= wr_next ? b : '0;
            wcolor_reg <= wr_next ? pen_reg : '0;
            orow_reg   <= crow_next;
            ocol_reg   <= ccol_next;
        end
    end

    assign cell_chan.valid          = out_valid_reg;
    assign cell_chan.cell_written   = wr_reg;
    assign cell_chan.cell_row       = wrow_reg;
    assign cell_chan.cell_col       = wcol_reg;
    assign cell_chan.cell_char      = wchar_reg;
    assign cell_chan.cell_color     = wcolor_reg;
    assign cell_chan.cursor_row_now = orow_reg;
    assign cell_chan.cursor_col_now = ocol_reg;

endmodule

### rtl/atpw_checker.sv
`timescale 1ns / 1ps

module atpw_checker
    import atpw_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               cell_written,
    input logic [ROW_W-1:0]   cell_row,
    input logic [COL_W-1:0]   cell_col,
    input logic [7:0]         cell_char,
    input logic [COLOR_W-1:0] cell_color,
    input logic [ROW_W-1:0]   cursor_row_now,
    input logic [COL_W-1:0]   cursor_col_now
);

    logic [1:0] pending_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Count bytes taken whose result has not been handed off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_xfer && !out_xfer && pending_reg != 2'd3)
            pending_reg <= pending_reg + 2'd1;
        else if (out_xfer && !in_xfer && pending_reg != 2'd0)
            pending_reg <= pending_reg - 2'd1;
    end

    a_result_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown with no byte outstanding");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd1)
        else $error("more than one result outstanding");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cell_written) |->
            (cell_row == '0 && cell_col == '0 && cell_char == '0 && cell_color == '0))
        else $error("cell fields set without a cell write");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(cell_written) && $stable(cell_char)
             && $stable(cursor_row_now) && $stable(cursor_col_now)))
        else $error("stalled result changed");

endmodule

bind ansi_text_plane_writer atpw_checker u_atpw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (byte_chan.valid),
    .in_ready       (byte_chan.ready),
    .out_valid      (cell_chan.valid),
    .out_ready      (cell_chan.ready),
    .cell_written   (cell_chan.cell_written),
    .cell_row       (cell_chan.cell_row),
    .cell_col       (cell_chan.cell_col),
    .cell_char      (cell_chan.cell_char),
    .cell_color     (cell_chan.cell_color),
    .cursor_row_now (cell_chan.cursor_row_now),
    .cursor_col_now (cell_chan.cursor_col_now)
);

### tb/ansi_text_plane_writer_tb.sv
`timescale 1ns / 1ps

module ansi_text_plane_writer_tb
    import atpw_pkg::*;
();

    // One result per byte: the cell it wrote (all zero when none) and the
    // cursor position after the byte.
    typedef struct packed {
        logic               written;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [7:0]         ch;
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   cur_row;
        logic [COL_W-1:0]   cur_col;
    } cell_result_t;

    // Tracks cursor, pen and escape parsing of the writer and keeps the
    // results still owed by the block, oldest first.
    class screen_tracker;
        logic [ROWS_W-1:0]  rows_reg;
        logic [COLS_W-1:0]  cols_reg;
        logic [ROW_W-1:0]   cur_row;
        logic [COL_W-1:0]   cur_col;
        logic [COLOR_W-1:0] pen;
        logic [6:0]         first_num;
        phase_t             phase;
        shape_t             shape;
        cell_result_t       expected_cells[$];
        int                 mismatches;

        function new();
            rows_reg   = ROWS_RESET;
            cols_reg   = COLS_RESET;
            cur_row    = '0;
            cur_col    = '0;
            pen        = PEN_RESET;
            first_num  = '0;
            phase      = PH_IDLE;
            shape      = SH_START;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_ROWS)
                rows_reg = val[ROWS_W-1:0];
            else
                cols_reg = val[COLS_W-1:0];
        endfunction

        function int clamp_count(int v, int top);
            if (v < 1)
                return 1;
            return (v > top) ? top : v;
        endfunction

        // Move down one row, held at the last row in use.
        function logic [ROW_W-1:0] row_below(int rows);
            int r;
            r = int'(cur_row) + 1;
            if (r > rows - 1)
                r = rows - 1;
            return r[ROW_W-1:0];
        endfunction

        // One byte of a CSI body or its final byte.
        function void csi_step(logic [7:0] b);
            int n;
            if (b >= FINAL_LOW && b <= FINAL_HIGH)
            begin
                if (b == SGR_FINAL && (shape == SH_FIRST || shape == SH_LATER) &&
                    first_num >= COLOR_FIRST && first_num <= COLOR_LAST)
                begin
                    n = int'(first_num) - int'(COLOR_FIRST);
                    pen = n[COLOR_W-1:0];
                end
                phase = PH_IDLE;
            end
            else if (b >= DIGIT_0 && b <= DIGIT_9)
            begin
                if (shape == SH_START || shape == SH_FIRST)
                begin
                    n = int'(first_num) * 10 + int'(b) - int'(DIGIT_0);
                    first_num = (n > int'(NUM_SAT)) ? NUM_SAT : n[6:0];
                    shape = SH_FIRST;
                end
                else if (shape == SH_SEMI)
                begin
                    shape = SH_LATER;
                end
            end
            else if (b == SEMICOLON)
            begin
                shape = (shape == SH_FIRST || shape == SH_LATER) ? SH_SEMI : SH_BROKEN;
            end
            else
            begin
                shape = SH_BROKEN;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            cell_result_t r;
            int rows;
            int cols;
            int c;
            bit fin;
            rows = clamp_count(int'(rows_reg), MAX_ROWS);
            cols = clamp_count(int'(cols_reg), MAX_COLS);
            fin  = (b >= FINAL_LOW && b <= FINAL_HIGH);
            r    = '0;
            case (phase)
                PH_ESC:
                    if (b == CSI_OPEN)
                    begin
                        phase     = PH_CSI;
                        first_num = '0;
                        shape     = SH_START;
                    end
                    else
                    begin
                        phase = fin ? PH_IDLE : PH_OTHER;
                    end
                PH_CSI:
                    csi_step(b);
                PH_OTHER:
                    if (fin)
                        phase = PH_IDLE;
                default:
                    if (b == ESC_BYTE)
                    begin
                        phase = PH_ESC;
                    end
                    else if (b == NEWLINE)
                    begin
                        cur_col = '0;
                        cur_row = row_below(rows);
                    end
                    else
                    begin
                        if (int'(cur_row) < rows && int'(cur_col) < cols)
                        begin
                            r.written = 1'b1;
                            r.row     = cur_row;
                            r.col     = cur_col;
                            r.ch      = b;
                            r.color   = pen;
                        end
                        c = (int'(cur_col) + 1) & 127;
                        if (c >= cols || c == 0)
                        begin
                            cur_col = '0;
                            cur_row = row_below(rows);
                        end
                        else
                        begin
                            cur_col = c[COL_W-1:0];
                        end
                    end
            endcase
            r.cur_row = cur_row;
            r.cur_col = cur_col;
            expected_cells.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_cell(cell_result_t got);
            cell_result_t want;
            if (expected_cells.size() == 0)
            begin
                $error("cell result with no byte outstanding");
                mismatches++;
                return;
            end
            want = expected_cells.pop_front();
            check_field("cell_written", 32'(want.written), 32'(got.written));
            check_field("cell_row", 32'(want.row), 32'(got.row));
            check_field("cell_col", 32'(want.col), 32'(got.col));
            check_field("cell_char", 32'(want.ch), 32'(got.ch));
            check_field("cell_color", 32'(want.color), 32'(got.color));
            check_field("cursor_row_now", 32'(want.cur_row), 32'(got.cur_row));
            check_field("cursor_col_now", 32'(want.cur_col), 32'(got.cur_col));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;

    atpw_byte_if byte_chan ();
    atpw_cell_if cell_chan ();

    screen_tracker tracker;

    // Chance in percent that a transfer is preceded by a gap (sender) or that
    // the receiver starts a stall; both drop to zero for the closing stretch.
    int tx_idle_pct;
    int rx_idle_pct;
    bit calm;
    int bytes_sent;

    ansi_text_plane_writer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .cell_chan (cell_chan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Hard stop: far beyond the slowest legal run, clearing pass included.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: check every transfer on the result channel, then decide
    // ready for the next edge.
    initial
    begin
        cell_result_t got;
        int stall_left;
        stall_left = 0;
        cell_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && cell_chan.valid === 1'b1 && cell_chan.ready === 1'b1)
            begin
                got.written = cell_chan.cell_written;
                got.row     = cell_chan.cell_row;
                got.col     = cell_chan.cell_col;
                got.ch      = cell_chan.cell_char;
                got.color   = cell_chan.cell_color;
                got.cur_row = cell_chan.cursor_row_now;
                got.cur_col = cell_chan.cursor_col_now;
                tracker.check_cell(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                cell_chan.ready <= 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct)
            begin
                stall_left = $urandom_range(0, 5);
                cell_chan.ready <= 1'b0;
            end
            else
            begin
                cell_chan.ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the block takes it. Valid stays high
    // on return so back-to-back bytes never toggle it within one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.valid   <= 1'b1;
        byte_chan.byte_in <= b;
        do
            @(posedge clk);
        while (byte_chan.ready !== 1'b1);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Drain every outstanding result, then change the screen geometry.
    task automatic set_geometry(input logic [CFG_W-1:0] rows_val,
                                input logic [CFG_W-1:0] cols_val);
        byte_chan.valid <= 1'b0;
        while (tracker.expected_cells.size() != 0)
            @(posedge clk);
        @(posedge clk);
        write_reg(REG_ROWS, rows_val);
        write_reg(REG_COLS, cols_val);
    endtask

    // Build and send one piece of terminal output: text, newlines, color
    // sequences (good and malformed), other escapes, or raw noise.
    task automatic send_chunk();
        logic [7:0] seq[$];
        int kind;
        int n;
        int num;
        string digits;
        if (calm || bytes_sent >= 560)
        begin
            calm = 1'b1;
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        else
        begin
            tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        end
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                n = $urandom_range(1, 10);
                repeat (n) seq.push_back(8'($urandom_range(8'h20, FINAL_HIGH)));
            end
            3:
            begin
                // Mostly one newline; now and then a run of 10 to 40 that can
                // pin the cursor on the last row.
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 1;
                repeat (n) seq.push_back(NEWLINE);
            end
            4, 5:
            begin
                // ESC [ params m: first number usually a color, empty
                // params and oversized numbers mixed in.
                seq.push_back(ESC_BYTE);
                seq.push_back(CSI_OPEN);
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    if (k > 0)
                        seq.push_back(SEMICOLON);
                    if ($urandom_range(0, 9) != 0)
                    begin
                        num = (k == 0 && $urandom_range(0, 3) != 0) ?
                              $urandom_range(30, 37) : $urandom_range(0, 300);
                        if ($urandom_range(0, 5) == 0)
                            seq.push_back(DIGIT_0);
                        digits = $sformatf("%0d", num);
                        for (int d = 0; d < digits.len(); d++)
                            seq.push_back(digits[d]);
                    end
                end
                seq.push_back(($urandom_range(0, 5) != 0) ?
                              SGR_FINAL : 8'($urandom_range(FINAL_LOW, FINAL_HIGH)));
            end
            6:
            begin
                // CSI with junk in the body (ESC and newline included).
                seq.push_back(ESC_BYTE);
                seq.push_back(CSI_OPEN);
                n = $urandom_range(0, 4);
                repeat (n) seq.push_back(8'($urandom_range(0, FINAL_LOW - 1)));
                seq.push_back(8'($urandom_range(FINAL_LOW, FINAL_HIGH)));
            end
            7:
            begin
                // Other escapes: a bare final byte (which may be '[') or intermediates first.
                seq.push_back(ESC_BYTE);
                n = $urandom_range(0, 3);
                repeat (n) seq.push_back(8'($urandom_range(0, FINAL_LOW - 1)));
                seq.push_back(8'($urandom_range(FINAL_LOW, FINAL_HIGH)));
            end
            default:
            begin
                n = $urandom_range(1, 6);
                repeat (n) seq.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic run_random(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_chunk();
    endtask

    initial
    begin
        logic [7:0] opening[$];
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] cols_val;
        tracker     = new();
        calm        = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        bytes_sent  = 0;

        rst_n             <= 1'b0;
        byte_chan.valid   <= 1'b0;
        byte_chan.byte_in <= 8'h00;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_ROWS;
        cfg_wdata         <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening at reset geometry: byte extremes, a newline, a red
        // pen, an empty SGR, white set by the first of two parameters, and an
        // escape with an intermediate that swallows a newline. The first
        // byte waits out the clearing pass.
        opening = '{8'h41, 8'h00, 8'hFF, NEWLINE,
                    ESC_BYTE, CSI_OPEN, DIGIT_0 + 8'd3, DIGIT_0 + 8'd1, SGR_FINAL,
                    8'h78,
                    ESC_BYTE, CSI_OPEN, SGR_FINAL,
                    ESC_BYTE, CSI_OPEN, DIGIT_0 + 8'd3, DIGIT_0 + 8'd7, SEMICOLON,
                    DIGIT_0 + 8'd1, SGR_FINAL,
                    ESC_BYTE, 8'h28, NEWLINE, 8'h42,
                    8'h7F};
        foreach (opening[i])
            send_byte(opening[i]);

        // Smallest screen: every printable wraps on the spot.
        set_geometry(8'd1, 8'd1);
        run_random(40);

        // Out-of-range values clamp to the largest screen; walk the cursor
        // down to the last row and across to the last column.
        set_geometry(8'd63, 8'd255);
        repeat (33) send_byte(NEWLINE);
        repeat (130) send_byte(8'($urandom_range(8'h20, FINAL_HIGH)));
        run_random(40);

        // Zero clamps to one; the cursor is now outside the area in use.
        set_geometry(8'd0, 8'd0);
        run_random(30);

        set_geometry(CFG_W'(MAX_ROWS), CFG_W'(MAX_COLS));
        run_random(30);
        set_geometry(8'd2, 8'd3);
        run_random(30);

        // Random geometries, mostly small so wraps and the row clamp recur.
        while (bytes_sent < 650)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    rows_val = CFG_W'($urandom_range(1, 4));
                    cols_val = CFG_W'($urandom_range(1, 10));
                end
                1:
                begin
                    rows_val = CFG_W'($urandom_range(1, MAX_ROWS));
                    cols_val = CFG_W'($urandom_range(1, MAX_COLS));
                end
                2:
                begin
                    rows_val = CFG_W'($urandom_range(0, 255));
                    cols_val = CFG_W'($urandom_range(0, 255));
                end
                default:
                begin
                    rows_val = CFG_W'($urandom_range(1, 8));
                    cols_val = CFG_W'($urandom_range(100, MAX_COLS));
                end
            endcase
            set_geometry(rows_val, cols_val);
            run_random($urandom_range(30, 70));
        end

        // Wait for the last results, then keep the clock running
        // so a stray extra result would still be caught.
        byte_chan.valid <= 1'b0;
        while (tracker.expected_cells.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
